// ===== design/page_bitmap_allocator_assert.svh =====
// assertion macros for the page bitmap allocator
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PAB_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pab assertion failed");
`define PAB_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pab assertion failed");
`else
`define PAB_ASSERT_NOW(label, cond, prop)
`define PAB_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== design/pab_pkg.sv =====
package pab_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 12;
    localparam int COUNT_W   = 13;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC_ONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE_ONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC_RUN = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FREE_RUN  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_BITS,
        S_MREAD,
        S_MCHECK,
        S_DONE
    } pab_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CONFIG,
        OP_INIT,
        OP_ACCEPT,
        OP_REJECT,
        OP_NOSPACE,
        OP_READ,
        OP_TAKE1,
        OP_FREE1,
        OP_FREEW,
        OP_SKIP,
        OP_LOAD,
        OP_BIT,
        OP_BITNEXT,
        OP_FOUND,
        OP_MARKW,
        OP_EMIT
    } pab_op_t;

    typedef struct packed {
        pab_op_t op;
    } pab_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              in_bad;
        logic              in_none;
        logic              init_last;
        logic              last_word;
        logic              hi_word;
        logic              word_nz;
        logic              word_skip;
        logic              bit_last;
        logic              bit_hit;
        logic              out_free;
    } pab_status_t;

endpackage

// ===== design/page_bitmap_allocator.sv =====
// free one reads and writes back one word; allocate one scans bitmap words until one has a
// free page; free run reads and writes back each word touched; allocate run skips whole words,
// scans others bit by bit through the one-port word loop, then marks each word of the run
// one request at a time: a new request is taken once the previous result is registered
// reset initialises the bitmap memory in a sweep over every word, and so does each cfg
// write; no request is taken during the sweep
`include "page_bitmap_allocator_assert.svh"

module page_bitmap_allocator #(
    parameter int MAX_PAGES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pab_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pab_pkg::KIND_W-1:0]    kind,
    input  logic [pab_pkg::INDEX_W-1:0]   page_index,
    input  logic [pab_pkg::COUNT_W-1:0]   count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pab_pkg::INDEX_W-1:0]   start_page,
    output logic [pab_pkg::STATUS_W-1:0]  status,
    output logic [pab_pkg::COUNT_W-1:0]   free_count
);

    import pab_pkg::*;

    pab_cmd_t    cmd;
    pab_status_t st;

    pab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .st        (st),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready)
    );

    pab_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .page_index (page_index),
        .count      (count),
        .start_page (start_page),
        .status     (status),
        .free_count (free_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

    // one request in flight
    `PAB_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
    // region write starts the clearing sweep
    `PAB_ASSERT_NEXT(a_sweep_after_config, cfg_valid && cfg_ready, in_stall && !cfg_ready)
    `PAB_ASSERT_NOW(a_fail_start_zero, out_valid && (status != STATUS_OK), start_page == '0)

endmodule

// ===== design/pab_ram.sv =====
module pab_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/pab_ctrl.sv =====
module pab_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                cfg_valid,
    input  pab_pkg::pab_status_t st,
    output pab_pkg::pab_cmd_t   cmd,
    output logic                in_stall,
    output logic                cfg_ready
);

    import pab_pkg::*;

    pab_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (st.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    state_next = S_INIT;
                end
                else if (in_valid)
                begin
                    state_next = (st.in_bad || st.in_none) ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                case (st.kind)
                    KIND_ALLOC_ONE:
                    begin
                        if (st.word_nz || st.last_word)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    KIND_FREE_ONE:
                    begin
                        state_next = S_DONE;
                    end
                    KIND_FREE_RUN:
                    begin
                        state_next = st.hi_word ? S_DONE : S_READ;
                    end
                    default:
                    begin
                        if (st.word_skip)
                        begin
                            state_next = st.last_word ? S_DONE : S_READ;
                        end
                        else
                        begin
                            state_next = S_BITS;
                        end
                    end
                endcase
            end
            S_BITS:
            begin
                if (st.bit_hit)
                begin
                    state_next = S_MREAD;
                end
                else if (st.bit_last)
                begin
                    state_next = st.last_word ? S_DONE : S_READ;
                end
            end
            S_MREAD:
            begin
                state_next = S_MCHECK;
            end
            S_MCHECK:
            begin
                state_next = st.hi_word ? S_DONE : S_MREAD;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_INIT;
            end
            S_IDLE:
            begin
                cfg_ready = 1'b1;
                in_stall  = cfg_valid;
                if (cfg_valid)
                begin
                    cmd.op = OP_CONFIG;
                end
                else if (in_valid)
                begin
                    if (st.in_bad)
                    begin
                        cmd.op = OP_REJECT;
                    end
                    else if (st.in_none)
                    begin
                        cmd.op = OP_NOSPACE;
                    end
                    else
                    begin
                        cmd.op = OP_ACCEPT;
                    end
                end
            end
            S_READ, S_MREAD:
            begin
                cmd.op = OP_READ;
            end
            S_CHECK:
            begin
                case (st.kind)
                    KIND_ALLOC_ONE:
                    begin
                        if (st.word_nz)
                        begin
                            cmd.op = OP_TAKE1;
                        end
                        else
                        begin
                            cmd.op = st.last_word ? OP_NOSPACE : OP_SKIP;
                        end
                    end
                    KIND_FREE_ONE:
                    begin
                        cmd.op = OP_FREE1;
                    end
                    KIND_FREE_RUN:
                    begin
                        cmd.op = OP_FREEW;
                    end
                    default:
                    begin
                        if (st.word_skip)
                        begin
                            cmd.op = st.last_word ? OP_NOSPACE : OP_SKIP;
                        end
                        else
                        begin
                            cmd.op = OP_LOAD;
                        end
                    end
                endcase
            end
            S_BITS:
            begin
                if (st.bit_hit)
                begin
                    cmd.op = OP_FOUND;
                end
                else if (st.bit_last)
                begin
                    cmd.op = st.last_word ? OP_NOSPACE : OP_BITNEXT;
                end
                else
                begin
                    cmd.op = OP_BIT;
                end
            end
            S_MCHECK:
            begin
                cmd.op = OP_MARKW;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

// ===== design/pab_dp.sv =====
module pab_dp #(
    parameter int MAX_PAGES = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pab_pkg::pab_cmd_t                 cmd,
    output pab_pkg::pab_status_t              st,
    input  logic [pab_pkg::COUNT_W-1:0]       cfg_data,
    input  logic [pab_pkg::KIND_W-1:0]        kind,
    input  logic [pab_pkg::INDEX_W-1:0]       page_index,
    input  logic [pab_pkg::COUNT_W-1:0]       count,
    output logic [pab_pkg::INDEX_W-1:0]       start_page,
    output logic [pab_pkg::STATUS_W-1:0]      status,
    output logic [pab_pkg::COUNT_W-1:0]       free_count,
    output logic                              out_valid,
    input  logic                              out_stall
);

    import pab_pkg::*;

    localparam int MAP_WORDS = MAX_PAGES / WORD_BITS;
    localparam int WA  = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int PGW = WA + BIT_W;
    localparam int PW  = $clog2(MAX_PAGES + 1);
    localparam int EW  = (PW > COUNT_W ? PW : COUNT_W) + 1;
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    function automatic logic [6:0] pop64(input logic [WORD_BITS-1:0] v);
        logic [3:0] b;
        logic [6:0] s;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            b = '0;
            for (int j = 0; j < 8; j++)
            begin
                b = b + 4'(v[8*i+j]);
            end
            s = s + 7'(b);
        end
        return s;
    endfunction

    logic [PW-1:0]        region_reg, region_next;
    logic [PW-1:0]        free_reg, free_next;
    logic [WA-1:0]        w_reg, w_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [PW-1:0]        run_reg, run_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [BIT_W-1:0]     sel_reg, sel_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [PGW-1:0]       lo_reg, lo_next;
    logic [PGW-1:0]       hi_reg, hi_next;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic [PGW-1:0]       start_reg, start_next;
    logic [STATUS_W-1:0]  stat_reg, stat_next;
    logic                 ov_reg, ov_next;
    logic [INDEX_W-1:0]   os_reg, os_next;
    logic [STATUS_W-1:0]  ostat_reg, ostat_next;
    logic [COUNT_W-1:0]   ofree_reg, ofree_next;

    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] rdata;

    logic [EW-1:0]        region_e;
    logic [EW-1:0]        base_e;
    logic [WORD_BITS-1:0] init_word;
    logic [WA-1:0]        last_w;
    logic [WORD_BITS-1:0] low_oh;
    logic [BIT_W-1:0]     low_enc;
    logic [WORD_BITS-1:0] sel_oh;
    logic [WORD_BITS-1:0] mask;
    logic [PW-1:0]        run_n;
    logic [PGW-1:0]       page;
    logic [EW-1:0]        found_e;
    logic [PW-1:0]        sat;

    pab_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (w_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (w_reg),
        .rdata (rdata)
    );

    assign region_e = EW'(region_reg);
    assign base_e   = EW'({w_reg, {BIT_W{1'b0}}});
    assign last_w   = WA'((region_e - EW'(1)) >> BIT_W);
    assign sat      = (EW'(cfg_data) > EW'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(cfg_data);

    always_comb
    begin
        if (region_e >= base_e + EW'(WORD_BITS))
        begin
            init_word = ONES;
        end
        else if (region_e <= base_e)
        begin
            init_word = '0;
        end
        else
        begin
            init_word = ~(ONES << region_reg[BIT_W-1:0]);
        end
    end

    // lowest free page in the word just read
    assign low_oh = rdata & (~rdata + WORD_BITS'(1));
    always_comb
    begin
        low_enc = '0;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            if (low_oh[k])
            begin
                low_enc = low_enc | BIT_W'(k);
            end
        end
    end

    assign sel_oh = WORD_BITS'(1) << sel_reg;

    // pages of the run that fall in the current word
    always_comb
    begin
        mask = ONES;
        if (w_reg == lo_reg[PGW-1:BIT_W])
        begin
            mask = mask & (ONES << lo_reg[BIT_W-1:0]);
        end
        if (w_reg == hi_reg[PGW-1:BIT_W])
        begin
            mask = mask & (ONES >> (BIT_W'(WORD_BITS - 1) - hi_reg[BIT_W-1:0]));
        end
    end

    assign run_n   = data_reg[bit_reg] ? run_reg + PW'(1) : '0;
    assign page    = {w_reg, bit_reg};
    assign found_e = EW'(page) + EW'(1) - EW'(cnt_reg);

    always_comb
    begin
        st.kind      = kind_reg;
        st.in_bad    = 1'b0;
        st.in_none   = 1'b0;
        case (kind)
            KIND_FREE_ONE:
            begin
                st.in_bad = EW'(page_index) >= region_e;
            end
            KIND_ALLOC_RUN:
            begin
                st.in_bad  = count == '0;
                st.in_none = region_reg == '0;
            end
            KIND_FREE_RUN:
            begin
                st.in_bad = (count == '0) || (EW'(page_index) + EW'(count) > region_e);
            end
            default:
            begin
                st.in_none = region_reg == '0;
            end
        endcase
        st.init_last = w_reg == WA'(MAP_WORDS - 1);
        st.last_word = w_reg == last_w;
        st.hi_word   = w_reg == hi_reg[PGW-1:BIT_W];
        st.word_nz   = rdata != '0;
        st.word_skip = (rdata == '0)
                    || ((&rdata) && (EW'(run_reg) + EW'(WORD_BITS) < EW'(cnt_reg)));
        st.bit_last  = &bit_reg;
        st.bit_hit   = EW'(run_n) == EW'(cnt_reg);
        st.out_free  = !ov_reg || !out_stall;
    end

    always_comb
    begin
        region_next = region_reg;
        free_next   = free_reg;
        w_next      = w_reg;
        bit_next    = bit_reg;
        run_next    = run_reg;
        kind_next   = kind_reg;
        sel_next    = sel_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        data_next   = data_reg;
        start_next  = start_reg;
        stat_next   = stat_reg;
        ov_next     = ov_reg && out_stall;
        os_next     = os_reg;
        ostat_next  = ostat_reg;
        ofree_next  = ofree_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = rdata;
        case (cmd.op)
            OP_CONFIG:
            begin
                region_next = sat;
                free_next   = sat;
                w_next      = '0;
            end
            OP_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = init_word;
                w_next    = w_reg + WA'(1);
            end
            OP_ACCEPT:
            begin
                kind_next  = kind;
                sel_next   = page_index[BIT_W-1:0];
                cnt_next   = count;
                run_next   = '0;
                stat_next  = STATUS_OK;
                start_next = '0;
                lo_next    = PGW'(page_index);
                hi_next    = PGW'(EW'(page_index) + EW'(count) - EW'(1));
                w_next     = kind[0] ? WA'(page_index >> BIT_W) : '0;
            end
            OP_REJECT:
            begin
                stat_next  = STATUS_BAD_RANGE;
                start_next = '0;
            end
            OP_NOSPACE:
            begin
                stat_next  = STATUS_NO_SPACE;
                start_next = '0;
            end
            OP_READ:
            begin
                ram_re = 1'b1;
            end
            OP_TAKE1:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rdata & ~low_oh;
                free_next  = free_reg - PW'(1);
                start_next = {w_reg, low_enc};
            end
            OP_FREE1:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata | sel_oh;
                if (!rdata[sel_reg])
                begin
                    free_next = free_reg + PW'(1);
                end
            end
            OP_FREEW:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata | mask;
                free_next = PW'(EW'(free_reg) + EW'(pop64(mask & ~rdata)));
                w_next    = w_reg + WA'(1);
            end
            OP_SKIP:
            begin
                run_next = (rdata == '0) ? '0 : PW'(EW'(run_reg) + EW'(WORD_BITS));
                w_next   = w_reg + WA'(1);
            end
            OP_LOAD:
            begin
                data_next = rdata;
                bit_next  = '0;
            end
            OP_BIT:
            begin
                run_next = run_n;
                bit_next = bit_reg + BIT_W'(1);
            end
            OP_BITNEXT:
            begin
                run_next = run_n;
                w_next   = w_reg + WA'(1);
            end
            OP_FOUND:
            begin
                start_next = PGW'(found_e);
                lo_next    = PGW'(found_e);
                hi_next    = page;
                w_next     = WA'(found_e >> BIT_W);
                free_next  = PW'(EW'(free_reg) - EW'(cnt_reg));
            end
            OP_MARKW:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata & ~mask;
                w_next    = w_reg + WA'(1);
            end
            OP_EMIT:
            begin
                ov_next    = 1'b1;
                os_next    = INDEX_W'(start_reg);
                ostat_next = stat_reg;
                ofree_next = COUNT_W'(free_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= PW'(MAX_PAGES);
            free_reg   <= PW'(MAX_PAGES);
            w_reg      <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            region_reg <= region_next;
            free_reg   <= free_next;
            w_reg      <= w_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg   <= bit_next;
        run_reg   <= run_next;
        kind_reg  <= kind_next;
        sel_reg   <= sel_next;
        cnt_reg   <= cnt_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        data_reg  <= data_next;
        start_reg <= start_next;
        stat_reg  <= stat_next;
        os_reg    <= os_next;
        ostat_reg <= ostat_next;
        ofree_reg <= ofree_next;
    end

    assign out_valid  = ov_reg;
    assign start_page = os_reg;
    assign status     = ostat_reg;
    assign free_count = ofree_reg;

endmodule
